// File: sv/energy_voice_activity_segmenter_defines.svh
// ----------------------------------------------------------------------------
// energy_voice_activity_segmenter_defines
// assertion macros shared by the segmenter rtl
// ----------------------------------------------------------------------------
`ifndef ENERGY_VOICE_ACTIVITY_SEGMENTER_DEFINES_SVH
`define ENERGY_VOICE_ACTIVITY_SEGMENTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled in reset
`define EVAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("evas assertion failed");
// next-cycle implication, disabled in reset
`define EVAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("evas assertion failed");
`else
`define EVAS_ASSERT_NOW(label, ante, cons)
`define EVAS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: sv/evas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evas_pkg
// types and fixed constants of the voice activity segmenter
// ----------------------------------------------------------------------------
package evas_pkg;

  localparam int MUL_W    = 32;
  localparam int SAMPLE_W = 16;

  typedef logic [MUL_W-1:0]   mul_op_t;
  typedef logic [2*MUL_W-1:0] mul_prod_t;

  // register indexes
  localparam logic [1:0] REG_THR  = 2'd0;
  localparam logic [1:0] REG_SIL  = 2'd1;
  localparam logic [1:0] REG_MIN  = 2'd2;
  localparam logic [1:0] REG_RATE = 2'd3;

  localparam logic [15:0] THR_RST  = 16'd500;
  localparam logic [15:0] SIL_RST  = 16'd800;
  localparam logic [15:0] MIN_RST  = 16'd300;
  localparam logic [17:0] RATE_RST = 18'd16000;

  localparam logic [15:0] SILENT_MAX = 16'hFFFF;
  localparam mul_op_t     MS_PER_S   = 32'd1000;

endpackage

// File: sv/energy_voice_activity_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// energy_voice_activity_segmenter
// frame energy speech detector that opens, extends and closes segments
// ----------------------------------------------------------------------------
// mid-frame sample: accept in IDLE, accumulate its square in ACC; flush: IDLE to EMIT
// frame-closing sample: ACC, LIM, CMP, SIL, END, RATE, KEEP; EMIT registers the result
// all products go through one shared registered 32x32 multiplier in sequence
// a result waiting on out_tready holds the sequencer in its emit step
// synchronous active-low reset: registers to defaults, segment and frame cleared
// ----------------------------------------------------------------------------
`include "energy_voice_activity_segmenter_defines.svh"

module energy_voice_activity_segmenter
  import evas_pkg::*;
#(
  parameter int unsigned     FRAME_MS            = 100,
  parameter int unsigned     MAX_FRAME_SAMPLES   = 8192,
  parameter longint unsigned MAX_SEGMENT_SAMPLES = 16777215
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample (signed)
  input  logic        in_tuser,   // [0] action (1 = flush)
  input  logic        in_tlast,   // frame_last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] segment_length
  output logic [3:0]  out_tuser,  // [0] frame_is_speech [1] in_speech [2] segment_done
                                  // [3] segment_kept
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int FRM_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int SEG_W = $clog2(MAX_SEGMENT_SAMPLES + 1);
  localparam int SQ_W  = 2 * SAMPLE_W - 1;
  localparam int ENG_W = SQ_W - 1 + FRM_W;
  localparam int SUM_W = ((SEG_W > FRM_W) ? SEG_W : FRM_W) + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_LIM  = 4'd2;
  localparam logic [3:0] S_CMP  = 4'd3;
  localparam logic [3:0] S_SIL  = 4'd4;
  localparam logic [3:0] S_END  = 4'd5;
  localparam logic [3:0] S_RATE = 4'd6;
  localparam logic [3:0] S_KEEP = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  // configuration registers
  logic [15:0] thr_r, sil_ms_r, min_ms_r;
  logic [17:0] rate_r;
  logic        cfg_wr;

  // sequencer and datapath state
  logic [3:0]       state_r, state_nxt;
  logic             flush_r, last_r;
  logic             active_r, speech_r, done_r, kept_r;
  logic [15:0]      cnt_r;
  logic [ENG_W-1:0] energy_r;
  logic [FRM_W-1:0] frame_cnt_r;
  logic [SEG_W-1:0] seg_r;
  mul_prod_t        hold_r;

  logic             out_valid_r;
  logic [23:0]      out_data_r;
  logic [3:0]       out_user_r;

  mul_op_t          op_a, op_b;
  mul_prod_t        prod;

  logic             in_acc;
  logic [15:0]      mag;
  logic             speech;
  logic [SUM_W-1:0] seg_sum;
  logic [SEG_W-1:0] seg_sat;
  logic             emit_go;
  logic             emit_done, emit_kept;
  logic [23:0]      emit_len;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= THR_RST;
      sil_ms_r <= SIL_RST;
      min_ms_r <= MIN_RST;
      rate_r   <= RATE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_THR:  thr_r    <= cfg_pwdata[15:0];
        REG_SIL:  sil_ms_r <= cfg_pwdata[15:0];
        REG_MIN:  min_ms_r <= cfg_pwdata[15:0];
        REG_RATE: rate_r   <= cfg_pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_THR:  cfg_prdata = {16'd0, thr_r};
      REG_SIL:  cfg_prdata = {16'd0, sil_ms_r};
      REG_MIN:  cfg_prdata = {16'd0, min_ms_r};
      REG_RATE: cfg_prdata = {14'd0, rate_r};
      default:  cfg_prdata = 32'd0;
    endcase
  end

  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign mag       = in_tdata[15] ? 16'(~in_tdata + 16'd1) : in_tdata;

  // operand select for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_IDLE: begin
        op_a = MUL_W'(mag);
        op_b = MUL_W'(mag);
      end
      S_ACC: begin
        op_a = MUL_W'(thr_r);
        op_b = MUL_W'(thr_r);
      end
      S_LIM: begin
        op_a = prod[MUL_W-1:0];
        op_b = MUL_W'(frame_cnt_r);
      end
      S_SIL: begin
        // silent count >= silence_ms / FRAME_MS  <=>  (count + 1) * FRAME_MS > silence_ms
        op_a = MUL_W'(cnt_r) + MUL_W'(1);
        op_b = MUL_W'(FRAME_MS);
      end
      S_END: begin
        op_a = MUL_W'(seg_r);
        op_b = MS_PER_S;
      end
      S_RATE: begin
        op_a = MUL_W'(rate_r);
        op_b = MUL_W'(min_ms_r);
      end
      default: ;
    endcase
  end

  evas_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  assign speech  = mul_prod_t'(energy_r) > prod;
  assign seg_sum = SUM_W'(seg_r) + SUM_W'(frame_cnt_r);
  assign seg_sat = (seg_sum > SUM_W'(MAX_SEGMENT_SAMPLES)) ?
                   SEG_W'(MAX_SEGMENT_SAMPLES) : SEG_W'(seg_sum);

  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign emit_done = flush_r ? active_r : done_r;
  assign emit_kept = flush_r ? (active_r && (seg_r != '0)) : (done_r && kept_r);
  assign emit_len  = active_r ? 24'(seg_r) : 24'd0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_tuser ? S_EMIT : S_ACC;
        end
      end
      S_ACC:  state_nxt = last_r ? S_LIM : S_IDLE;
      S_LIM:  state_nxt = S_CMP;
      S_CMP:  state_nxt = S_SIL;
      S_SIL:  state_nxt = S_END;
      S_END:  state_nxt = S_RATE;
      S_RATE: state_nxt = S_KEEP;
      S_KEEP: state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      cnt_r       <= '0;
      energy_r    <= '0;
      frame_cnt_r <= '0;
      seg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_ACC: begin
          // samples past the frame limit are dropped from the sums
          if (frame_cnt_r < FRM_W'(MAX_FRAME_SAMPLES)) begin
            energy_r    <= energy_r + ENG_W'(prod);
            frame_cnt_r <= frame_cnt_r + FRM_W'(1);
          end
        end
        S_CMP: begin
          if (speech || active_r) begin
            seg_r <= seg_sat;
          end
          if (speech) begin
            active_r <= 1'b1;
            cnt_r    <= '0;
          end else if (active_r && cnt_r != SILENT_MAX) begin
            cnt_r <= cnt_r + 16'd1;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            if (flush_r || done_r) begin
              active_r <= 1'b0;
              cnt_r    <= '0;
              seg_r    <= '0;
            end
            energy_r    <= '0;
            frame_cnt_r <= '0;
          end
        end
        default: ;
      endcase
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      flush_r <= in_tuser;
      last_r  <= in_tlast;
    end
    if (state_r == S_CMP) begin
      speech_r <= speech;
    end
    if (state_r == S_END) begin
      done_r <= !speech_r && active_r && (prod > mul_prod_t'(sil_ms_r));
    end
    if (state_r == S_RATE) begin
      hold_r <= prod;
    end
    if (state_r == S_KEEP) begin
      kept_r <= hold_r >= prod;
    end
    if (emit_go) begin
      out_data_r <= emit_len;
      out_user_r <= {emit_kept, emit_done,
                     !flush_r && active_r && !done_r,
                     !flush_r && speech_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `EVAS_ASSERT_NOW(a_cnt_in_seg, !active_r, cnt_r == '0)
  `EVAS_ASSERT_NOW(a_seg_in_seg, !active_r, seg_r == '0)
  `EVAS_ASSERT_NOW(a_frame_lim, 1'b1, frame_cnt_r <= FRM_W'(MAX_FRAME_SAMPLES))
  `EVAS_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready)

endmodule

// File: sv/evas_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evas_mul
// shared 32x32 multiplier with registered product
// ----------------------------------------------------------------------------
module evas_mul
  import evas_pkg::*;
(
  input  logic      clk,
  input  mul_op_t   op_a,
  input  mul_op_t   op_b,
  output mul_prod_t prod
);

  mul_prod_t prod_r;
  mul_prod_t prod_nxt;

  assign prod_nxt = mul_prod_t'(op_a) * mul_prod_t'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the energy voice activity segmenter: drives pcm
// samples, frame ends and flushes, predicts every frame and segment decision
// in-bench, and checks each result as it leaves the block under random stalls
// ----------------------------------------------------------------------------
module tb;
  import evas_pkg::*;

  localparam int unsigned     FRAME_MS          = 100;
  localparam int unsigned     MAX_FRAME_SAMPLES = 8192;
  localparam longint unsigned MAX_SEG_SAMPLES   = 16777215;
  localparam int              HOLD_CYCLES       = 400;
  localparam int              SETTLE_CYCLES     = 16;
  localparam int              WATCHDOG_LIMIT    = 5000;
  localparam int              MAX_PRINTED       = 30;

  typedef struct packed {
    logic        speech;
    logic        in_seg;
    logic        done;
    logic        kept;
    logic [23:0] len;
  } seg_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] sample (signed)
  logic        in_tuser;   // [0] action (1 = flush)
  logic        in_tlast;   // frame_last
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [23:0] segment_length
  logic [3:0]  out_tuser;  // [0] frame_is_speech [1] in_speech [2] segment_done [3] segment_kept
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  energy_voice_activity_segmenter u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // register mirror
  logic [15:0] thr_reg;
  logic [15:0] sil_reg;
  logic [15:0] min_reg;
  logic [17:0] rate_reg;

  // predicted segmenter state
  bit              seg_open;
  int unsigned     silent_run;
  longint unsigned frame_energy;
  int unsigned     frame_count;
  longint unsigned seg_len;

  seg_result_t pending_results[$];

  int  mismatches;
  int  items_sent;
  int  results_seen;
  int  speech_frames;
  int  segments_ended;
  int  segments_kept;
  bit  quiet_tail;
  bit  hold_req;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  // computes the result that one accepted request causes, if any
  task automatic predict_segment_step(input logic act, input logic [15:0] smp,
                                      input logic last);
    seg_result_t     r;
    longint unsigned mag;
    longint unsigned limit;
    bit              speech;
    r = '0;
    if (act) begin
      r.done = seg_open;
      r.kept = seg_open && seg_len != 0;
      r.len  = seg_open ? seg_len[23:0] : 24'd0;
      seg_open     = 1'b0;
      silent_run   = 0;
      seg_len      = 0;
      frame_energy = 0;
      frame_count  = 0;
      pending_results.push_back(r);
      return;
    end
    if (frame_count < MAX_FRAME_SAMPLES) begin
      mag = smp[15] ? (longint'(17'h10000) - longint'(smp)) : longint'(smp);
      frame_energy += mag * mag;
      frame_count++;
    end
    if (!last) return;
    limit  = longint'(thr_reg) * longint'(thr_reg) * longint'(frame_count);
    speech = frame_energy > limit;
    if (speech || seg_open) begin
      seg_len += frame_count;
      if (seg_len > MAX_SEG_SAMPLES) seg_len = MAX_SEG_SAMPLES;
    end
    if (speech) begin
      seg_open   = 1'b1;
      silent_run = 0;
      r.len      = seg_len[23:0];
    end else if (seg_open) begin
      if (silent_run < SILENT_MAX) silent_run++;
      r.len = seg_len[23:0];
      if (silent_run >= sil_reg / FRAME_MS) begin
        r.done     = 1'b1;
        r.kept     = seg_len * MS_PER_S >= longint'(min_reg) * longint'(rate_reg);
        seg_open   = 1'b0;
        silent_run = 0;
        seg_len    = 0;
      end
    end
    frame_energy = 0;
    frame_count  = 0;
    r.speech = speech;
    r.in_seg = seg_open;
    pending_results.push_back(r);
  endtask

  task automatic send_item(input logic act, input logic [15:0] smp, input logic last);
    int gap;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= smp;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_segment_step(act, smp, last);
    items_sent++;
  endtask

  // waits until the block has nothing left in flight
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_THR:  thr_reg  = val[15:0];
      REG_SIL:  sil_reg  = val[15:0];
      REG_MIN:  min_reg  = val[15:0];
      REG_RATE: rate_reg = val[17:0];
      default: ;
    endcase
    want = (idx == REG_RATE) ? {14'd0, val[17:0]} : {16'd0, val[15:0]};
    // read back
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want)
      report_mismatch($sformatf("register %0d read %0h want %0h", idx, cfg_prdata, want));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic send_frame(input int n, input logic [15:0] smp);
    for (int k = 0; k < n; k++) send_item(1'b0, smp, k == n - 1);
  endtask

  function automatic logic [15:0] loud_sample(input int unsigned thr);
    int unsigned mag;
    mag = thr + $urandom_range(1, 3 * thr + 1);
    if (mag > 32767) mag = 32767;
    return $urandom_range(0, 1) ? -16'(mag) : 16'(mag);
  endfunction

  function automatic logic [15:0] quiet_sample(input int unsigned thr);
    int unsigned mag;
    mag = $urandom_range(0, thr / 2);
    return $urandom_range(0, 1) ? -16'(mag) : 16'(mag);
  endfunction

  // reset defaults: frame decisions, threshold boundary, flush in all positions
  task automatic test_basics();
    send_item(1'b0, 16'h7FFF, 1'b0);
    send_item(1'b0, 16'h8000, 1'b1);   // opens a segment
    send_item(1'b0, 16'h0000, 1'b1);   // silent frame inside it
    send_item(1'b1, 16'h5A5A, 1'b1);   // flush with junk flags
    send_item(1'b1, 16'h0000, 1'b0);   // flush with nothing open
    send_item(1'b0, 16'd500, 1'b1);    // exactly at threshold is silence
    send_item(1'b0, 16'hFE0C, 1'b0);
    send_item(1'b0, 16'd501, 1'b1);
    send_item(1'b0, 16'h7FFF, 1'b0);
    send_item(1'b1, 16'hFFFF, 1'b0);   // flush drops the partial frame
    send_item(1'b0, 16'h0000, 1'b1);
    settle();
  endtask

  task automatic test_threshold_extremes();
    cfg_write(REG_THR, 32'd0);
    cfg_write(REG_SIL, 32'd0);
    send_frame(2, 16'h0000);           // no energy, still silence
    send_frame(1, 16'h0001);           // speech
    send_frame(1, 16'h0000);           // first silent frame ends it
    settle();
    cfg_write(REG_THR, 32'd32768);
    send_frame(3, 16'h8000);           // full scale cannot exceed it
    send_frame(1, 16'h7FFF);
    settle();
  endtask

  task automatic test_duration_limits();
    cfg_write(REG_THR, 32'd100);
    cfg_write(REG_MIN, 32'd65535);
    cfg_write(REG_RATE, 32'd1);
    send_frame(65, 16'd4000);          // just long enough with the closing frame
    send_frame(1, 16'd0);
    send_frame(64, 16'hF000);          // one sample short
    send_frame(1, 16'd0);
    settle();
    cfg_write(REG_RATE, 32'd192000);
    send_frame(5, 16'd4000);
    send_frame(1, 16'd0);
    settle();
    cfg_write(REG_RATE, 32'd0);
    send_frame(1, 16'd4000);
    send_frame(1, 16'd0);
    settle();
    cfg_write(REG_MIN, 32'd0);
    cfg_write(REG_RATE, 32'd1);
    cfg_write(REG_SIL, 32'd65535);
    send_frame(1, 16'd4000);
    for (int k = 0; k < 6; k++) send_frame(1, 16'd0);
    send_item(1'b1, 16'd0, 1'b0);
    settle();
  endtask

  task automatic test_backpressure();
    cfg_write(REG_THR, 32'd300);
    cfg_write(REG_SIL, 32'd200);
    hold_req = 1'b1;
    for (int k = 0; k < 40; k++)
      send_frame(1, (k % 5 < 2) ? loud_sample(300) : quiet_sample(300));
    // sender waits for the block to drain fully
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    for (int k = 0; k < 10; k++)
      send_frame(1, (k % 3 == 0) ? loud_sample(300) : quiet_sample(300));
    settle();
  endtask

  task automatic test_random_traffic(input int n_items);
    int          target;
    int unsigned thr;
    int          pick;
    int          len;
    bit          talking;
    thr = $urandom_range(50, 3000);
    cfg_write(REG_THR, thr);
    cfg_write(REG_SIL, $urandom_range(0, 700));
    cfg_write(REG_MIN, $urandom_range(0, 120));
    cfg_write(REG_RATE, $urandom_range(200, 3000));
    target  = items_sent + n_items;
    talking = 1'b0;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_item(1'b1, 16'($urandom), 1'($urandom));
      end else if (pick < 14) begin
        send_item(1'b0, 16'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++)
          send_item(1'b0, talking ? loud_sample(thr) : quiet_sample(thr), k == len - 1);
        if ($urandom_range(0, 9) < 3) talking = !talking;
      end
    end
    settle();
  endtask

  // result receiver with random stalls and one long hold-off
  initial begin : receiver
    int stall;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet_tail && rst_n && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 14);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    seg_result_t got;
    seg_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tuser[1], out_tuser[2], out_tuser[3], out_tdata};
      results_seen++;
      speech_frames  += got.speech;
      segments_ended += got.done;
      segments_kept  += got.done && got.kept;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (got.speech !== want.speech)
          report_mismatch($sformatf("frame_is_speech %0b want %0b", got.speech, want.speech));
        if (got.in_seg !== want.in_seg)
          report_mismatch($sformatf("in_speech %0b want %0b", got.in_seg, want.in_seg));
        if (got.done !== want.done)
          report_mismatch($sformatf("segment_done %0b want %0b", got.done, want.done));
        if (got.kept !== want.kept)
          report_mismatch($sformatf("segment_kept %0b want %0b", got.kept, want.kept));
        if (got.len !== want.len)
          report_mismatch($sformatf("segment_length %0d want %0d", got.len, want.len));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    thr_reg     = THR_RST;
    sil_reg     = SIL_RST;
    min_reg     = MIN_RST;
    rate_reg    = RATE_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basics();
    test_threshold_extremes();
    test_duration_limits();
    test_backpressure();
    test_random_traffic(230);
    test_random_traffic(230);
    quiet_tail = 1'b1;
    test_random_traffic(230);
    $display("sent %0d requests, checked %0d results, %0d speech frames",
             items_sent, results_seen, speech_frames);
    $display("%0d segments closed, %0d kept, %0d mismatches",
             segments_ended, segments_kept, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
